// ===== rtl/rle_text_row_decoder_core_macros.svh =====
// assertion macros shared by the rle text row decoder checker
`ifndef RLE_TEXT_ROW_DECODER_CORE_MACROS_SVH
`define RLE_TEXT_ROW_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define RTDEC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define RTDEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rtdec_pkg.sv =====
// shared types and constants of the rle text row decoder
package rtdec_pkg;

   localparam int unsigned MAX_RUN_DEFAULT = 32;
   localparam int unsigned RUN_CNT_W       = 6;
   localparam int unsigned CMD_FIFO_DEPTH  = 2;

   localparam logic [1:0] KIND_CELL      = 2'd0;
   localparam logic [1:0] KIND_ROW_END   = 2'd1;
   localparam logic [1:0] KIND_LEVEL_END = 2'd2;

   localparam logic [7:0] ROW_END_BYTE   = 8'h7C;
   localparam logic [7:0] LEVEL_END_BYTE = 8'h3B;
   localparam logic [7:0] DIGIT_ZERO     = 8'h30;
   localparam logic [7:0] DIGIT_NINE     = 8'h39;

   typedef struct packed {
      logic [7:0]           symbol;
      logic [RUN_CNT_W-1:0] cell_count;
      logic                 row_end;
      logic                 level_end;
   } cmd_type;

endpackage

// ===== rtl/rtdec_if.sv =====
// request and response channel interfaces of the rle text row decoder
interface rtdec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       line_end;

   modport source (output valid, output text_byte, output line_end, input ready);
   modport sink (input valid, input text_byte, input line_end, output ready);
endinterface

interface rtdec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cell_symbol;
   logic [1:0] kind;
   logic       last;

   modport source (output valid, output cell_symbol, output kind, output last, input ready);
   modport sink (input valid, input cell_symbol, input kind, input last, output ready);
endinterface

// ===== rtl/rtdec_front.sv =====
// front end: tracks line state and turns bytes into result commands where a byte yields one
module rtdec_front #(
   parameter int unsigned MaxRun = rtdec_pkg::MAX_RUN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          text_byte,
   input  logic                line_end,
   output logic                push,
   output rtdec_pkg::cmd_type  cmd
);

   localparam int unsigned CntW = rtdec_pkg::RUN_CNT_W;
   localparam int unsigned AccW = CntW + 4;

   logic [CntW-1:0] run_count_ff, run_count_in;
   logic            have_digits_ff, have_digits_in;
   logic            row_open_ff, row_open_in;
   logic            level_closed_ff, level_closed_in;

   logic [AccW-1:0] acc;
   logic [CntW-1:0] run_cnt;
   logic            is_digit;

   assign is_digit = (text_byte >= rtdec_pkg::DIGIT_ZERO) && (text_byte <= rtdec_pkg::DIGIT_NINE);
   assign acc      = {4'd0, run_count_ff} * AccW'(10) + {{CntW{1'b0}}, text_byte[3:0]};
   assign run_cnt  = have_digits_ff ? run_count_ff : CntW'(1);

   always_comb begin
      run_count_in    = run_count_ff;
      have_digits_in  = have_digits_ff;
      row_open_in     = row_open_ff;
      level_closed_in = level_closed_ff;
      cmd             = '0;
      cmd.symbol      = text_byte;
      if (accept && !level_closed_ff) begin
         if (text_byte == rtdec_pkg::ROW_END_BYTE) begin
            cmd.row_end    = 1'b1;
            row_open_in    = 1'b0;
            run_count_in   = '0;
            have_digits_in = 1'b0;
         end else if (text_byte == rtdec_pkg::LEVEL_END_BYTE) begin
            cmd.row_end     = row_open_ff;
            cmd.level_end   = 1'b1;
            row_open_in     = 1'b0;
            run_count_in    = '0;
            have_digits_in  = 1'b0;
            level_closed_in = 1'b1;
         end else if (is_digit) begin
            run_count_in   = (acc > AccW'(MaxRun)) ? CntW'(MaxRun) : acc[CntW-1:0];
            have_digits_in = 1'b1;
         end else begin
            cmd.cell_count = run_cnt;
            if (run_cnt != '0) begin
               row_open_in = 1'b1;
            end
            run_count_in   = '0;
            have_digits_in = 1'b0;
         end
         // close the line: open row first, then the level
         if (line_end && !level_closed_in) begin
            cmd.row_end   = cmd.row_end | row_open_in;
            cmd.level_end = 1'b1;
         end
      end
      if (accept && line_end) begin
         run_count_in    = '0;
         have_digits_in  = 1'b0;
         row_open_in     = 1'b0;
         level_closed_in = 1'b0;
      end
   end

   assign push = accept && !level_closed_ff &&
                 ((cmd.cell_count != '0) || cmd.row_end || cmd.level_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff    <= '0;
         have_digits_ff  <= 1'b0;
         row_open_ff     <= 1'b0;
         level_closed_ff <= 1'b0;
      end else begin
         run_count_ff    <= run_count_in;
         have_digits_ff  <= have_digits_in;
         row_open_ff     <= row_open_in;
         level_closed_ff <= level_closed_in;
      end
   end

endmodule

// ===== rtl/rtdec_cmd_fifo.sv =====
// short command queue between front and back
module rtdec_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rtdec_pkg::cmd_type push_cmd,
   input  logic               pop,
   output rtdec_pkg::cmd_type pop_cmd,
   output logic               full,
   output logic               empty
);

   localparam int unsigned Depth = rtdec_pkg::CMD_FIFO_DEPTH;
   localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW  = $clog2(Depth + 1);

   rtdec_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/rtdec_back.sv =====
// back end: expands one command into result beats through an output register
module rtdec_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_empty,
   input  rtdec_pkg::cmd_type cmd,
   output logic               pop,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [7:0]         rsp_cell_symbol,
   output logic [1:0]         rsp_kind,
   output logic               rsp_last
);

   localparam int unsigned CntW = rtdec_pkg::RUN_CNT_W;

   logic            active_ff, active_in;
   logic [CntW-1:0] cells_left_ff, cells_left_in;
   logic            row_pend_ff, row_pend_in;
   logic            level_pend_ff, level_pend_in;
   logic [7:0]      symbol_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_sym_ff;
   logic [1:0]      rsp_kind_ff;
   logic            rsp_last_ff;

   logic            advance;
   logic [7:0]      nxt_sym;
   logic [1:0]      nxt_kind;
   logic            nxt_last;

   assign pop     = !active_ff && !cmd_empty;
   assign advance = active_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cells_left_in = cells_left_ff;
      row_pend_in   = row_pend_ff;
      level_pend_in = level_pend_ff;
      nxt_sym       = 8'd0;
      nxt_kind      = rtdec_pkg::KIND_LEVEL_END;
      nxt_last      = 1'b1;
      if (cells_left_ff != '0) begin
         nxt_sym       = symbol_ff;
         nxt_kind      = rtdec_pkg::KIND_CELL;
         nxt_last      = (cells_left_ff == CntW'(1)) && !row_pend_ff && !level_pend_ff;
         cells_left_in = cells_left_ff - CntW'(1);
      end else if (row_pend_ff) begin
         nxt_kind    = rtdec_pkg::KIND_ROW_END;
         nxt_last    = !level_pend_ff;
         row_pend_in = 1'b0;
      end else begin
         level_pend_in = 1'b0;
      end
      active_in = active_ff;
      if (pop) begin
         active_in = 1'b1;
      end else if (advance && nxt_last) begin
         active_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cells_left_ff <= cmd.cell_count;
         row_pend_ff   <= cmd.row_end;
         level_pend_ff <= cmd.level_end;
         symbol_ff     <= cmd.symbol;
      end else if (advance) begin
         cells_left_ff <= cells_left_in;
         row_pend_ff   <= row_pend_in;
         level_pend_ff <= level_pend_in;
      end
      if (advance) begin
         rsp_sym_ff  <= nxt_sym;
         rsp_kind_ff <= nxt_kind;
         rsp_last_ff <= nxt_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_symbol = rsp_sym_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== rtl/rle_text_row_decoder_core.sv =====
// top level of the rle text row decoder
// decodes one line of run-length coded level text, one byte per request beat,
// into cell, row end and level end response beats. a byte is taken by the
// front end whenever the two-entry command queue has room; the
// back end picks up each command and then emits its beats from its output
// register, taking no new command until the current one's last beat; a
// byte that yields no beats never reaches the back end. throughput is set
// by the back end's single output register: one response beat per cycle
// within a command when rsp is not stalled.
// digits saturate at MaxRun, so one byte yields at most MaxRun + 2 beats.
module rle_text_row_decoder_core #(
   parameter int unsigned MaxRun = rtdec_pkg::MAX_RUN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rtdec_req_if.sink   req_bus,
   rtdec_rsp_if.source rsp_bus
);

   // command path from front end to back end
   rtdec_pkg::cmd_type front_cmd;
   rtdec_pkg::cmd_type back_cmd;
   logic               front_push;
   logic               back_pop;
   logic               queue_full;
   logic               queue_empty;
   logic               req_accept;

   // a byte is accepted whenever the queue can take its command
   assign req_bus.ready = !queue_full;
   assign req_accept    = req_bus.valid && !queue_full;

   // front end: digit accumulation, row and level tracking
   rtdec_front #(
      .MaxRun (MaxRun)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .text_byte (req_bus.text_byte),
      .line_end  (req_bus.line_end),
      .push      (front_push),
      .cmd       (front_cmd)
   );

   // decouples byte intake from beat expansion
   rtdec_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .pop      (back_pop),
      .pop_cmd  (back_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // back end: cells, then row end, then level end, last on the final beat
   rtdec_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (queue_empty),
      .cmd             (back_cmd),
      .pop             (back_pop),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_cell_symbol (rsp_bus.cell_symbol),
      .rsp_kind        (rsp_bus.kind),
      .rsp_last        (rsp_bus.last)
   );

endmodule

// ===== rtl/rtdec_checker.sv =====
// port-level checker of the rle text row decoder and its bind
`include "rle_text_row_decoder_core_macros.svh"

module rtdec_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_cell_symbol,
   input logic [1:0] rsp_kind,
   input logic       rsp_last
);

   `RTDEC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cell_symbol) && $stable(rsp_kind) && $stable(rsp_last), "response beat changed while stalled")
   `RTDEC_ASSERT_NOW(a_kind_legal, rsp_valid, rsp_kind != 2'd3, "response kind out of range")
   `RTDEC_ASSERT_NOW(a_marker_symbol, rsp_valid && (rsp_kind != rtdec_pkg::KIND_CELL), rsp_cell_symbol == 8'd0, "row or level end carries a symbol")
   `RTDEC_ASSERT_NOW(a_level_last, rsp_valid && (rsp_kind == rtdec_pkg::KIND_LEVEL_END), rsp_last, "level end is not the final beat")

endmodule

bind rle_text_row_decoder_core rtdec_checker u_rtdec_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_cell_symbol (rsp_bus.cell_symbol),
   .rsp_kind        (rsp_bus.kind),
   .rsp_last        (rsp_bus.last)
);
